[design/ppei_pkg.sv]
// Shared types and constants of the polyline against polygon edge ring test.
// Used by the channel interfaces, the front end and the job queue.
package ppei_pkg;

  localparam int POINT_W = 16;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    REQ_VERTEX = 1'b0,
    REQ_CORNER = 1'b1
  } req_type_t;

endpackage

[design/ppei_if.sv]
// Valid/ready channel interfaces for the point input and the hit result.
// Depends on ppei_pkg for the coordinate field width.
interface ppei_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [ppei_pkg::POINT_W-1:0] point_x;
  logic signed [ppei_pkg::POINT_W-1:0] point_y;
  logic                                last_corner;

  modport source(output valid, req_type, point_x, point_y, last_corner, input ready);
  modport sink(input valid, req_type, point_x, point_y, last_corner, output ready);
endinterface

interface ppei_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source(output valid, hit, input ready);
  modport sink(input valid, hit, output ready);
endinterface

[design/ppei_queue.sv]
// Short FIFO of edge jobs between the front end and the intersection back end.
// Depends on ppei_pkg for its depth.
module ppei_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  localparam int AW = (ppei_pkg::QUEUE_DEPTH > 1) ? $clog2(ppei_pkg::QUEUE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(ppei_pkg::QUEUE_DEPTH - 1);
  localparam logic [AW:0] FULL_COUNT = (AW + 1)'(ppei_pkg::QUEUE_DEPTH);

  logic [W-1:0]  slot_r [ppei_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count_r != FULL_COUNT;
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
    end
    count_nxt = count_r + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[design/ppei_front.sv]
// Front end: accepts points, keeps the polyline and ring corners, and issues edge jobs.
// Depends on ppei_pkg and ppei_in_if; feeds ppei_queue.
module ppei_front #(
  parameter int CW = 16,
  parameter int NV = 3,
  localparam int JW = 2 + 2 * NV * CW + 4 * CW
) (
  input  logic          clk,
  input  logic          rst_n,
  ppei_in_if.sink       in_ch,
  output logic          push_valid,
  input  logic          push_ready,
  output logic [JW-1:0] push_job
);

  typedef struct packed {
    logic                test;
    logic                emit;
    logic [NV-1:0][CW-1:0] vx;
    logic [NV-1:0][CW-1:0] vy;
    logic [CW-1:0]       ax;
    logic [CW-1:0]       ay;
    logic [CW-1:0]       bx;
    logic [CW-1:0]       by;
  } edge_job_t;

  localparam int EW = (CW > ppei_pkg::POINT_W) ? CW : ppei_pkg::POINT_W;

  logic [NV-1:0][CW-1:0] vx_r, vy_r;
  logic [CW-1:0]         first_x_r, first_y_r;
  logic [CW-1:0]         prev_x_r, prev_y_r;
  logic                  seen_r;
  logic                  pend_r;
  edge_job_t             pend_job_r;
  edge_job_t             new_job;
  edge_job_t             close_job;
  logic                  new_push;
  logic                  accept;
  logic                  is_corner;
  logic signed [EW-1:0]  ext_x, ext_y;
  logic [CW-1:0]         cx, cy;

  assign ext_x     = EW'(in_ch.point_x);
  assign ext_y     = EW'(in_ch.point_y);
  assign cx        = ext_x[CW-1:0];
  assign cy        = ext_y[CW-1:0];
  assign in_ch.ready = !pend_r && push_ready;
  assign accept    = in_ch.valid && in_ch.ready;
  assign is_corner = in_ch.req_type == ppei_pkg::REQ_CORNER;

  always_comb begin
    new_job.test = seen_r;
    new_job.emit = !seen_r;
    new_job.vx   = vx_r;
    new_job.vy   = vy_r;
    new_job.ax   = prev_x_r;
    new_job.ay   = prev_y_r;
    new_job.bx   = cx;
    new_job.by   = cy;
    close_job.test = 1'b1;
    close_job.emit = 1'b1;
    close_job.vx   = vx_r;
    close_job.vy   = vy_r;
    close_job.ax   = cx;
    close_job.ay   = cy;
    close_job.bx   = first_x_r;
    close_job.by   = first_y_r;
  end

  assign new_push   = accept && is_corner && (seen_r || in_ch.last_corner);
  assign push_valid = pend_r || new_push;
  assign push_job   = pend_r ? JW'(pend_job_r) : JW'(new_job);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r      <= '0;
      vy_r      <= '0;
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      seen_r    <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      if (pend_r && push_ready) begin
        pend_r <= 1'b0;
      end
      if (accept) begin
        if (!is_corner) begin
          vx_r <= {cx, vx_r[NV-1:1]};
          vy_r <= {cy, vy_r[NV-1:1]};
        end else begin
          prev_x_r <= cx;
          prev_y_r <= cy;
          if (!seen_r) begin
            first_x_r <= cx;
            first_y_r <= cy;
          end
          if (in_ch.last_corner) begin
            seen_r <= 1'b0;
            pend_r <= seen_r;
          end else begin
            seen_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_corner && in_ch.last_corner) begin
      pend_job_r <= close_job;
    end
  end

`ifndef SYNTHESIS
  // A pending closing edge means the ring has already been closed.
  a_pend_ring_closed: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !seen_r)
    else $error("closing edge pending while ring still open");

  // The front end never offers two jobs in one cycle.
  a_single_push: assert property (@(posedge clk) disable iff (!rst_n)
    new_push |-> !pend_r)
    else $error("new job issued while closing edge pending");
`endif

endmodule

[design/ppei_back.sv]
// Back end: pipelined segment against edge test over all polyline segments in parallel.
// Accumulates hits per ring and holds the result; depends on ppei_out_if.
module ppei_back #(
  parameter int CW = 16,
  parameter int NV = 3,
  localparam int JW = 2 + 2 * NV * CW + 4 * CW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  logic [JW-1:0] job_data,
  output logic          job_pop,
  ppei_out_if.source    out_ch
);

  typedef struct packed {
    logic                test;
    logic                emit;
    logic [NV-1:0][CW-1:0] vx;
    logic [NV-1:0][CW-1:0] vy;
    logic [CW-1:0]       ax;
    logic [CW-1:0]       ay;
    logic [CW-1:0]       bx;
    logic [CW-1:0]       by;
  } edge_job_t;

  localparam int NS = NV - 1;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  function automatic logic signed [DW-1:0] sx(input logic [CW-1:0] v);
    sx = $signed({v[CW-1], v});
  endfunction

  function automatic logic in_unit(input logic signed [NW-1:0] num,
                                   input logic signed [NW-1:0] den);
    if (!den[NW-1]) begin
      in_unit = !num[NW-1] && (num <= den);
    end else begin
      in_unit = (num[NW-1] || num == '0) && (num >= den);
    end
  endfunction

  edge_job_t job;
  logic      en;

  logic signed [DW-1:0] d2x, d2y;
  logic signed [DW-1:0] d1x [NS];
  logic signed [DW-1:0] d1y [NS];
  logic signed [DW-1:0] ex [NS];
  logic signed [DW-1:0] ey [NS];

  logic                 a_valid_r, a_test_r, a_emit_r;
  logic signed [DW-1:0] a_d2x_r, a_d2y_r;
  logic signed [DW-1:0] a_d1x_r [NS];
  logic signed [DW-1:0] a_d1y_r [NS];
  logic signed [DW-1:0] a_ex_r [NS];
  logic signed [DW-1:0] a_ey_r [NS];

  logic                 b_valid_r, b_test_r, b_emit_r;
  logic signed [PW-1:0] b_den1_r [NS];
  logic signed [PW-1:0] b_den2_r [NS];
  logic signed [PW-1:0] b_na1_r [NS];
  logic signed [PW-1:0] b_na2_r [NS];
  logic signed [PW-1:0] b_nb1_r [NS];
  logic signed [PW-1:0] b_nb2_r [NS];

  logic                 c_valid_r, c_test_r, c_emit_r;
  logic signed [NW-1:0] c_den_r [NS];
  logic signed [NW-1:0] c_na_r [NS];
  logic signed [NW-1:0] c_nb_r [NS];

  logic [NS-1:0] lane_hit;
  logic          edge_hit;
  logic          acc_r;
  logic          out_valid_r;
  logic          out_hit_r;

  assign job     = edge_job_t'(job_data);
  assign en      = !out_valid_r || out_ch.ready;
  assign job_pop = en && job_valid;

  assign d2x = sx(job.bx) - sx(job.ax);
  assign d2y = sx(job.by) - sx(job.ay);

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      d1x[k] = sx(job.vx[k+1]) - sx(job.vx[k]);
      d1y[k] = sx(job.vy[k+1]) - sx(job.vy[k]);
      ex[k]  = sx(job.vx[k]) - sx(job.ax);
      ey[k]  = sx(job.vy[k]) - sx(job.ay);
    end
  end

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      lane_hit[k] = (c_den_r[k] != '0) && in_unit(c_na_r[k], c_den_r[k]) &&
                    in_unit(c_nb_r[k], c_den_r[k]);
    end
  end

  assign edge_hit = c_test_r && (|lane_hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r   <= job_valid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      out_valid_r <= c_valid_r && c_emit_r;
      if (c_valid_r) begin
        acc_r <= c_emit_r ? 1'b0 : (acc_r | edge_hit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_test_r <= job.test;
      a_emit_r <= job.emit;
      a_d2x_r  <= d2x;
      a_d2y_r  <= d2y;
      b_test_r <= a_test_r;
      b_emit_r <= a_emit_r;
      c_test_r <= b_test_r;
      c_emit_r <= b_emit_r;
      for (int k = 0; k < NS; k++) begin
        a_d1x_r[k]  <= d1x[k];
        a_d1y_r[k]  <= d1y[k];
        a_ex_r[k]   <= ex[k];
        a_ey_r[k]   <= ey[k];
        b_den1_r[k] <= PW'(a_d1x_r[k]) * PW'(a_d2y_r);
        b_den2_r[k] <= PW'(a_d2x_r) * PW'(a_d1y_r[k]);
        b_na1_r[k]  <= PW'(a_d1x_r[k]) * PW'(a_ey_r[k]);
        b_na2_r[k]  <= PW'(a_d1y_r[k]) * PW'(a_ex_r[k]);
        b_nb1_r[k]  <= PW'(a_d2x_r) * PW'(a_ey_r[k]);
        b_nb2_r[k]  <= PW'(a_d2y_r) * PW'(a_ex_r[k]);
        c_den_r[k]  <= NW'(b_den1_r[k]) - NW'(b_den2_r[k]);
        c_na_r[k]   <= NW'(b_na1_r[k]) - NW'(b_na2_r[k]);
        c_nb_r[k]   <= NW'(b_nb1_r[k]) - NW'(b_nb2_r[k]);
      end
      if (c_valid_r && c_emit_r) begin
        out_hit_r <= acc_r | edge_hit;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = out_hit_r;

`ifndef SYNTHESIS
  // A job without an edge to test only exists to close a single-corner ring.
  a_untested_emits: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r && !c_test_r |-> c_emit_r)
    else $error("edge job without test that does not emit");

  // The hit accumulator starts clean after every ring result.
  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    en && c_valid_r && c_emit_r |=> !acc_r)
    else $error("hit accumulator not cleared at ring end");

  // A result register is loaded only when a ring has just been finished.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && !(en && c_valid_r && c_emit_r) |=> !out_valid_r)
    else $error("result appeared without a ring end");
`endif

endmodule

[design/polyline_polygon_edge_intersect.sv]
// Polyline against polygon edge ring intersection test, top level.
// The hit is registered once the ring's last job has passed the queue and back end stages a-c.
// Throughput: one item per cycle while the job queue has room; a ring's last corner with an
// open edge holds off input until its closing edge is pushed on the single shared push port.
// Reset (synchronous, rst_n low) clears the polyline store, ring state, queue and pipeline.
// Depends on ppei_pkg, ppei_if, ppei_queue, ppei_front and ppei_back.
module polyline_polygon_edge_intersect #(
  parameter int COORD_WIDTH = 16,
  parameter int POLY_VERTICES = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  ppei_in_if.sink    in_ch,
  ppei_out_if.source out_ch
);

  localparam int JW = 2 + 2 * POLY_VERTICES * COORD_WIDTH + 4 * COORD_WIDTH;

  logic          push_valid;
  logic          push_ready;
  logic [JW-1:0] push_job;
  logic          job_pop;
  logic          job_valid;
  logic [JW-1:0] job_data;

  ppei_front #(
    .CW(COORD_WIDTH),
    .NV(POLY_VERTICES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job)
  );

  ppei_queue #(
    .W(JW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_job),
    .pop       (job_pop),
    .pop_valid (job_valid),
    .pop_data  (job_data)
  );

  ppei_back #(
    .CW(COORD_WIDTH),
    .NV(POLY_VERTICES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(job_valid),
    .job_data (job_data),
    .job_pop  (job_pop),
    .out_ch   (out_ch)
  );

endmodule

[dv/polyline_polygon_edge_intersect_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for polyline_polygon_edge_intersect: directed and random rings checked
// against a ring tracker class. Depends on ppei_pkg, ppei_if and the block's design files.
module polyline_polygon_edge_intersect_test;

  localparam int LINE_POINTS = 3;
  localparam int SETTLE_CYCLES = 16;
  localparam int TIMEOUT_NS = 2_000_000;

  typedef logic signed [ppei_pkg::POINT_W-1:0] coord_t;

  class edge_ring_tracker;
    longint line_x[LINE_POINTS];
    longint line_y[LINE_POINTS];
    longint ring_x0, ring_y0, tail_x, tail_y;
    bit ring_open;
    bit ring_hit;
    bit hits_due[$];
    int errors;
    int rings_done;
    int rings_hit;

    function bit in_unit(longint num, longint den);
      if (den > 0) return num >= 0 && num <= den;
      return num <= 0 && num >= den;
    endfunction

    function bit segments_meet(longint p1x, longint p1y, longint p2x, longint p2y,
                               longint t1x, longint t1y, longint t2x, longint t2y);
      longint d1x, d1y, d2x, d2y, ex, ey, den, na, nb;
      d1x = p2x - p1x;
      d1y = p2y - p1y;
      d2x = t2x - t1x;
      d2y = t2y - t1y;
      ex = p1x - t1x;
      ey = p1y - t1y;
      den = d1x * d2y - d2x * d1y;
      na = d1x * ey - d1y * ex;
      nb = d2x * ey - d2y * ex;
      if (den == 0) return 1'b0;
      return in_unit(na, den) && in_unit(nb, den);
    endfunction

    function bit edge_crosses(longint ax, longint ay, longint bx, longint by);
      bit any;
      any = 1'b0;
      for (int k = 0; k + 1 < LINE_POINTS; k++) begin
        if (segments_meet(line_x[k], line_y[k], line_x[k+1], line_y[k+1], ax, ay, bx, by))
          any = 1'b1;
      end
      return any;
    endfunction

    function void take_point(ppei_pkg::req_type_t kind, coord_t x, coord_t y, bit last);
      longint px, py;
      px = x;
      py = y;
      if (kind == ppei_pkg::REQ_VERTEX) begin
        for (int k = 0; k + 1 < LINE_POINTS; k++) begin
          line_x[k] = line_x[k+1];
          line_y[k] = line_y[k+1];
        end
        line_x[LINE_POINTS-1] = px;
        line_y[LINE_POINTS-1] = py;
        return;
      end
      if (!ring_open) begin
        ring_x0 = px;
        ring_y0 = py;
        ring_open = 1'b1;
        ring_hit = 1'b0;
      end else if (edge_crosses(tail_x, tail_y, px, py)) begin
        ring_hit = 1'b1;
      end
      tail_x = px;
      tail_y = py;
      if (!last) return;
      if (edge_crosses(px, py, ring_x0, ring_y0)) ring_hit = 1'b1;
      hits_due.push_back(ring_hit);
      ring_open = 1'b0;
      ring_hit = 1'b0;
    endfunction

    function void check_hit(bit got);
      bit want;
      if (hits_due.size() == 0) begin
        $error("hit: no result expected, actual %0b", got);
        errors++;
        return;
      end
      want = hits_due.pop_front();
      rings_done++;
      if (got) rings_hit++;
      if (got !== want) begin
        $error("hit mismatch: expected %0b, actual %0b", want, got);
        errors++;
      end
    endfunction

    function void report_leftovers();
      foreach (hits_due[i]) begin
        $error("hit: expected %0b never arrived", hits_due[i]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int src_idle_pct;
  int sink_idle_pct;
  int points_sent;
  edge_ring_tracker tracker;

  ppei_in_if in_ch();
  ppei_out_if out_ch();

  polyline_polygon_edge_intersect DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      tracker.check_hit(out_ch.hit);
  end

  initial begin
    #TIMEOUT_NS;
    $display("Verification failed");
    $finish;
  end

  task automatic send_point(ppei_pkg::req_type_t kind, coord_t x, coord_t y, bit last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.last_corner <= last;
    do @(negedge clk); while (in_ch.ready !== 1'b1);
    tracker.take_point(kind, x, y, last);
    points_sent++;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (tracker.hits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int span);
    if (span >= 32768) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic run_directed();
    send_point(ppei_pkg::REQ_VERTEX, -32768, -32768, 1'b0);
    send_point(ppei_pkg::REQ_VERTEX, 32767, 32767, 1'b1);
    send_point(ppei_pkg::REQ_VERTEX, -32768, 32767, 1'b0);
    // A lone corner marked last has only a degenerate edge.
    send_point(ppei_pkg::REQ_CORNER, 5, 5, 1'b1);
    send_point(ppei_pkg::REQ_CORNER, -100, -100, 1'b0);
    send_point(ppei_pkg::REQ_CORNER, 100, -100, 1'b0);
    send_point(ppei_pkg::REQ_CORNER, 100, 100, 1'b0);
    send_point(ppei_pkg::REQ_CORNER, -100, 100, 1'b1);
    send_point(ppei_pkg::REQ_VERTEX, 0, 0, 1'b0);
    send_point(ppei_pkg::REQ_VERTEX, 10, 0, 1'b0);
    send_point(ppei_pkg::REQ_VERTEX, 20, 0, 1'b0);
    // Parallel edge, then a collinear overlapping edge; neither counts as a hit.
    send_point(ppei_pkg::REQ_CORNER, 0, 5, 1'b0);
    send_point(ppei_pkg::REQ_CORNER, 20, 5, 1'b1);
    send_point(ppei_pkg::REQ_CORNER, 0, 0, 1'b0);
    send_point(ppei_pkg::REQ_CORNER, 20, 0, 1'b1);
    // An edge that ends exactly on the polyline still hits.
    send_point(ppei_pkg::REQ_CORNER, 5, -5, 1'b0);
    send_point(ppei_pkg::REQ_CORNER, 5, 0, 1'b1);
    // The polyline moves away in the middle of a ring.
    send_point(ppei_pkg::REQ_CORNER, 32767, -32768, 1'b0);
    send_point(ppei_pkg::REQ_VERTEX, 32767, 32767, 1'b0);
    send_point(ppei_pkg::REQ_CORNER, -32768, 32767, 1'b0);
    send_point(ppei_pkg::REQ_CORNER, -32768, -32768, 1'b1);
  endtask

  task automatic run_random(int target);
    int stop_at;
    int span;
    int corners;
    int mid;
    coord_t x0, y0, x1, y1;
    coord_t cx[4];
    coord_t cy[4];
    stop_at = points_sent + target;
    while (points_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        send_point(ppei_pkg::req_type_t'($urandom_range(0, 1)), coord_t'($urandom),
                   coord_t'($urandom), 1'($urandom_range(0, 1)));
        continue;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: span = 64;
        7, 8: span = 4096;
        default: span = 32768;
      endcase
      if ($urandom_range(0, 2) != 0) begin
        repeat (LINE_POINTS)
          send_point(ppei_pkg::REQ_VERTEX, rand_coord(span), rand_coord(span),
                     1'($urandom_range(0, 1)));
      end
      mid = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
      if ($urandom_range(0, 3) != 0) begin
        x0 = rand_coord(span);
        y0 = rand_coord(span);
        x1 = rand_coord(span);
        y1 = rand_coord(span);
        cx = '{x0, x1, x1, x0};
        cy = '{y0, y0, y1, y1};
        corners = 4;
      end else begin
        corners = $urandom_range(1, 4);
        for (int i = 0; i < 4; i++) begin
          cx[i] = rand_coord(span);
          cy[i] = rand_coord(span);
        end
      end
      for (int i = 0; i < corners; i++) begin
        if (mid != 0 && mid == i)
          send_point(ppei_pkg::REQ_VERTEX, rand_coord(span), rand_coord(span), 1'b0);
        send_point(ppei_pkg::REQ_CORNER, cx[i], cy[i], i == corners - 1);
      end
    end
  endtask

  initial begin
    tracker = new();
    points_sent = 0;
    src_idle_pct = 20;
    sink_idle_pct = 58;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= ppei_pkg::REQ_VERTEX;
    in_ch.point_x <= '0;
    in_ch.point_y <= '0;
    in_ch.last_corner <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    wait_drained();
    run_random(200);
    wait_drained();
    src_idle_pct = 58;
    sink_idle_pct = 20;
    run_random(200);
    wait_drained();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    run_random(200);
    wait_drained();

    tracker.report_leftovers();
    $display("Sent %0d points; checked %0d ring results, %0d of them with a hit.",
             points_sent, tracker.rings_done, tracker.rings_hit);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[files.f]
design/ppei_pkg.sv
design/ppei_if.sv
design/ppei_queue.sv
design/ppei_front.sv
design/ppei_back.sv
design/polyline_polygon_edge_intersect.sv
dv/polyline_polygon_edge_intersect_test.sv
